// ===== design/cdq_pkg.sv =====
// Shared types and constants for the circular deque core.
package cdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FILL_W        = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE       = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_EMPTY      = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } ctl_state_t;

  typedef struct packed {
    action_t                    action;
    logic signed [DATA_W-1:0]   push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   popped_value;
    status_t                    status;
    logic [FILL_W-1:0]          fill_level;
    logic                       now_empty;
    logic                       now_full;
  } out_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic    capture;
    logic    commit;
    logic    push_ok;
    logic    pop_ok;
    logic    front;
    status_t status;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_t action;
    logic    empty;
    logic    full;
  } dp_stat_t;

endpackage

// ===== design/cdq_ctrl.sv =====
// Controller state machine: accepts a request and decides its outcome.
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::dp_stat_t stat,
  output cdq_pkg::dp_cmd_t  cmd
);

  cdq_pkg::ctl_state_t state_r, state_nxt;
  logic is_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign is_push = (stat.action == cdq_pkg::ACT_PUSH_REAR) ||
                   (stat.action == cdq_pkg::ACT_PUSH_FRONT);

  always_comb begin
    state_nxt   = state_r;
    busy        = 1'b0;
    cmd         = '0;
    cmd.status  = cdq_pkg::STAT_DONE;
    unique case (state_r)
      cdq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = cdq_pkg::ST_COMMIT;
        end
      end
      cdq_pkg::ST_COMMIT: begin
        busy       = 1'b1;
        cmd.commit = 1'b1;
        cmd.front  = (stat.action == cdq_pkg::ACT_PUSH_FRONT) ||
                     (stat.action == cdq_pkg::ACT_POP_FRONT);
        if (is_push) begin
          if (stat.full) begin
            cmd.status = cdq_pkg::STAT_FULL;
          end else begin
            cmd.push_ok = 1'b1;
          end
        end else begin
          if (stat.empty) begin
            cmd.status = cdq_pkg::STAT_EMPTY;
          end else begin
            cmd.pop_ok = 1'b1;
          end
        end
        state_nxt = cdq_pkg::ST_IDLE;
      end
      default: state_nxt = cdq_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/cdq_datapath.sv =====
// Datapath: slot memory, head/tail pointers, fill count and result register.
module cdq_datapath #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_pkg::in_req_t  in_req,
  input  cdq_pkg::dp_cmd_t  cmd,
  output cdq_pkg::dp_stat_t stat,
  output logic              out_strobe,
  output cdq_pkg::out_rsp_t out_rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

  cdq_pkg::in_req_t           req_r;
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [cdq_pkg::DATA_W-1:0] rd_data_r;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic                       out_strobe_r;
  cdq_pkg::out_rsp_t          out_rsp_r, out_rsp_nxt;

  // Pops read at the pointer on their own side.
  assign rd_addr = (in_req.action == cdq_pkg::ACT_POP_FRONT) ? head_r : tail_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    wr_addr   = tail_r + AW'(1);
    if (cmd.push_ok) begin
      count_nxt = count_r + CW'(1);
      if (count_r == '0) begin
        head_nxt = '0;
        tail_nxt = '0;
        wr_addr  = '0;
      end else if (cmd.front) begin
        head_nxt = head_r - AW'(1);
        wr_addr  = head_r - AW'(1);
      end else begin
        tail_nxt = tail_r + AW'(1);
      end
    end else if (cmd.pop_ok) begin
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else if (cmd.front) begin
        head_nxt = head_r + AW'(1);
      end else begin
        tail_nxt = tail_r - AW'(1);
      end
    end
  end

  always_comb begin
    out_rsp_nxt              = '0;
    out_rsp_nxt.popped_value = cmd.pop_ok ? rd_data_r : '0;
    out_rsp_nxt.status       = cmd.status;
    out_rsp_nxt.fill_level   = cdq_pkg::FILL_W'(count_nxt);
    out_rsp_nxt.now_empty    = (count_nxt == '0);
    out_rsp_nxt.now_full     = (count_nxt == CW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= in_req;
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.push_ok) begin
      mem[wr_addr] <= req_r.push_value;
    end
    if (cmd.commit) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= cmd.commit;
    end
  end

  assign stat.action = req_r.action;
  assign stat.empty  = (count_r == '0);
  assign stat.full   = (count_r == CW'(DEPTH));

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

// ===== design/circular_deque_core.sv =====
// Top level of the circular deque: controller plus datapath.
//
//  channel | ports                  | handshake
//  --------+------------------------+--------------------------------------
//  request | start, busy, in_req    | taken on an edge with start & !busy
//  result  | out_strobe, out_rsp    | one cycle per result, cannot be held
//
// A request takes two steps: the accept step reads the slot memory port
// into a register, the commit step updates pointers, writes the slot and
// loads the result register. The result shows in the cycle after commit,
// while a new request may already be accepted. Requests do not overlap:
// busy holds off a new request during the commit step.
// Reset is synchronous and active low; it empties the queue, slot contents
// are left as they are. The receiver has no way to stall results.
module circular_deque_core #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output cdq_pkg::out_rsp_t out_rsp
);

  cdq_pkg::dp_cmd_t  cmd;
  cdq_pkg::dp_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

endmodule

// ===== design/cdq_checker.sv =====
// Port-level checks for the circular deque, bound to the top level.
module cdq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input cdq_pkg::out_rsp_t out_rsp
);

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  a_busy_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe && !busy)
    else $error("commit did not produce a result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_rsp.status == cdq_pkg::STAT_DONE ||
                   out_rsp.status == cdq_pkg::STAT_FULL ||
                   out_rsp.status == cdq_pkg::STAT_EMPTY)
    else $error("result carries an unused status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_rsp.status != cdq_pkg::STAT_DONE |-> out_rsp.popped_value == '0)
    else $error("refused request returned a nonzero value");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_rsp.now_empty && out_rsp.now_full))
    else $error("queue reported empty and full at once");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);
